// ===== hdl/bdg_pkg.sv =====
// ----------------------------------------------------------------------------
// bdg_pkg
// Shared widths, register indexes, payload structs and the 8x8 threshold
// matrix for the diagonal ordered-dither gradient.
// ----------------------------------------------------------------------------
`default_nettype none

package bdg_pkg;

   localparam int COL_W      = 9;
   localparam int SCREEN_W   = 10;
   localparam int SPAN_REG_W = 10;
   localparam int DENS_W     = 7;
   localparam int THRESH_W   = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;

   localparam int DENS_MAX   = 64;
   localparam int MIX_SHIFT  = 6;
   localparam int SUM_W      = 11;
   localparam int STEP_BITS  = 3;
   localparam int DIV_STEPS  = 6;
   localparam int DIV_W      = STEP_BITS * DIV_STEPS;
   localparam int MIX_W      = 15;
   localparam int DIFF_W     = DENS_W + 1;
   localparam int PROD_W     = 24;
   localparam int QUO_W      = PROD_W - MIX_SHIFT;
   localparam int DENSITY_W  = QUO_W + 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_X   = 3'd0,
      CSR_ORIGIN_Y   = 3'd1,
      CSR_WIDTH      = 3'd2,
      CSR_HEIGHT     = 3'd3,
      CSR_DENS_BEGIN = 3'd4,
      CSR_DENS_END   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [SCREEN_W-1:0] screen_x;
      logic [SCREEN_W-1:0] screen_y;
      logic [THRESH_W-1:0] thresh;
   } side_type;

   typedef struct packed {
      logic [COL_W-1:0]  origin_x;
      logic [COL_W-1:0]  origin_y;
      logic [DENS_W-1:0] dens_begin;
      logic [DENS_W-1:0] dens_end;
   } cfg_type;

   // row-major, index is {row[2:0], col[2:0]}
   localparam logic [THRESH_W-1:0] BAYER_TABLE [64] = '{
       0, 48, 12, 60,  3, 51, 15, 63,
      32, 16, 44, 28, 35, 19, 47, 31,
       8, 56,  4, 52, 11, 59,  7, 55,
      40, 24, 36, 20, 43, 27, 39, 23,
       2, 50, 14, 62,  1, 49, 13, 61,
      34, 18, 46, 30, 33, 17, 45, 29,
      10, 58,  6, 54,  9, 57,  5, 53,
      42, 26, 38, 22, 41, 25, 37, 21
   };

   function automatic logic [THRESH_W-1:0] bayer_thresh(input logic [2:0] r,
                                                        input logic [2:0] c);
      return BAYER_TABLE[{r, c}];
   endfunction

   function automatic logic [DENS_W-1:0] clamp_density(input logic [DENS_W-1:0] v);
      return (v > DENS_W'(DENS_MAX)) ? DENS_W'(DENS_MAX) : v;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/bdg_if.sv =====
// ----------------------------------------------------------------------------
// bdg channel interfaces
// Valid/ready channels for the pixel offset items and the screen result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdg_req_if;
   import bdg_pkg::*;

   logic             valid;
   logic             ready;
   logic [COL_W-1:0] col;
   logic [COL_W-1:0] row;

   modport source (output valid, output col, output row, input ready);
   modport sink   (input valid, input col, input row, output ready);
endinterface

interface bdg_rsp_if;
   import bdg_pkg::*;

   logic                valid;
   logic                ready;
   logic [SCREEN_W-1:0] screen_x;
   logic [SCREEN_W-1:0] screen_y;
   logic                paint_red;

   modport source (output valid, output screen_x, output screen_y, output paint_red,
                   input ready);
   modport sink   (input valid, input screen_x, input screen_y, input paint_red,
                   output ready);
endinterface

`default_nettype wire

// ===== hdl/bdg_csr.sv =====
// ----------------------------------------------------------------------------
// bdg_csr
// Configuration registers; spans and densities are clamped when written and
// the blend divisor 2*width + height is kept ready in a register.
// ----------------------------------------------------------------------------
`default_nettype none

module bdg_csr #(
   parameter int SPAN_CAP = 512,
   parameter int DEN_W    = 11
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [bdg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bdg_pkg::CSR_DATA_W-1:0]   csr_write_data,
   output bdg_pkg::cfg_type                 cfg,
   output logic [DEN_W-1:0]                 divisor
);
   import bdg_pkg::*;

   localparam int SPAN_W = $clog2(SPAN_CAP + 1);

   logic [COL_W-1:0]  origin_x_ff,   origin_x_in;
   logic [COL_W-1:0]  origin_y_ff,   origin_y_in;
   logic [SPAN_W-1:0] width_ff,      width_in;
   logic [SPAN_W-1:0] height_ff,     height_in;
   logic [DEN_W-1:0]  divisor_ff,    divisor_in;
   logic [DENS_W-1:0] dens_begin_ff, dens_begin_in;
   logic [DENS_W-1:0] dens_end_ff,   dens_end_in;
   logic [SPAN_W-1:0] span_wr;

   function automatic logic [SPAN_W-1:0] clamp_span(input logic [SPAN_REG_W-1:0] v);
      if (v == '0) begin
         return SPAN_W'(1);
      end else if (32'(v) > SPAN_CAP) begin
         return SPAN_W'(SPAN_CAP);
      end else begin
         return SPAN_W'(v);
      end
   endfunction

   assign span_wr = clamp_span(csr_write_data[SPAN_REG_W-1:0]);

   always_comb begin
      origin_x_in   = origin_x_ff;
      origin_y_in   = origin_y_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      divisor_in    = divisor_ff;
      dens_begin_in = dens_begin_ff;
      dens_end_in   = dens_end_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_ORIGIN_X: begin
               origin_x_in = csr_write_data[COL_W-1:0];
            end
            CSR_ORIGIN_Y: begin
               origin_y_in = csr_write_data[COL_W-1:0];
            end
            CSR_WIDTH: begin
               width_in   = span_wr;
               divisor_in = DEN_W'({span_wr, 1'b0}) + DEN_W'(height_ff);
            end
            CSR_HEIGHT: begin
               height_in  = span_wr;
               divisor_in = DEN_W'({width_ff, 1'b0}) + DEN_W'(span_wr);
            end
            CSR_DENS_BEGIN: begin
               dens_begin_in = clamp_density(csr_write_data[DENS_W-1:0]);
            end
            CSR_DENS_END: begin
               dens_end_in = clamp_density(csr_write_data[DENS_W-1:0]);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff   <= '0;
         origin_y_ff   <= '0;
         width_ff      <= SPAN_W'(1);
         height_ff     <= SPAN_W'(1);
         divisor_ff    <= DEN_W'(3);
         dens_begin_ff <= '0;
         dens_end_ff   <= '0;
      end else begin
         origin_x_ff   <= origin_x_in;
         origin_y_ff   <= origin_y_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         divisor_ff    <= divisor_in;
         dens_begin_ff <= dens_begin_in;
         dens_end_ff   <= dens_end_in;
      end
   end

   assign cfg.origin_x   = origin_x_ff;
   assign cfg.origin_y   = origin_y_ff;
   assign cfg.dens_begin = dens_begin_ff;
   assign cfg.dens_end   = dens_end_ff;
   assign divisor        = divisor_ff;

`ifndef SYNTHESIS
   a_divisor_tracks_spans: assert property (@(posedge clock) disable iff (reset)
      divisor_ff == DEN_W'({width_ff, 1'b0}) + DEN_W'(height_ff))
      else $error("divisor out of step with width and height");
   a_span_nonzero: assert property (@(posedge clock) disable iff (reset)
      csr_write_en && (csr_index == CSR_WIDTH || csr_index == CSR_HEIGHT)
      |=> width_ff != '0 && height_ff != '0)
      else $error("span register holds zero after write");
   a_density_clamped: assert property (@(posedge clock) disable iff (reset)
      csr_write_en && (csr_index == CSR_DENS_BEGIN || csr_index == CSR_DENS_END)
      |=> dens_begin_ff <= DENS_W'(DENS_MAX) && dens_end_ff <= DENS_W'(DENS_MAX))
      else $error("density register above full scale");
`endif

endmodule

`default_nettype wire

// ===== hdl/bdg_div_step.sv =====
// ----------------------------------------------------------------------------
// bdg_div_step
// One pipeline stage of the restoring divider: retires a few quotient bits
// of the blend position and carries the pixel sideband along.
// ----------------------------------------------------------------------------
`default_nettype none

module bdg_div_step #(
   parameter int DEN_W = 11
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [bdg_pkg::DIV_W-1:0]     in_nq,
   input  logic [DEN_W-1:0]              in_rem,
   input  bdg_pkg::side_type             in_side,
   input  logic [DEN_W-1:0]              divisor,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [bdg_pkg::DIV_W-1:0]     out_nq,
   output logic [DEN_W-1:0]              out_rem,
   output bdg_pkg::side_type             out_side
);
   import bdg_pkg::*;

   logic             valid_ff;
   logic [DIV_W-1:0] nq_ff, nq_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   side_type         side_ff;
   logic [DIV_W-1:0] nq_work;
   logic [DEN_W-1:0] rem_work;
   logic [DEN_W:0]   trial;

   // nq shifts numerator bits out at the top and quotient bits in at the bottom
   always_comb begin
      nq_work  = in_nq;
      rem_work = in_rem;
      trial    = '0;
      for (int k = 0; k < STEP_BITS; k++) begin
         trial   = {rem_work, nq_work[DIV_W-1]};
         nq_work = {nq_work[DIV_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            trial      = trial - {1'b0, divisor};
            nq_work[0] = 1'b1;
         end
         rem_work = trial[DEN_W-1:0];
      end
      nq_in  = nq_work;
      rem_in = rem_work;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         nq_ff   <= nq_in;
         rem_ff  <= rem_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_nq    = nq_ff;
   assign out_rem   = rem_ff;
   assign out_side  = side_ff;

endmodule

`default_nettype wire

// ===== hdl/bdg_blend.sv =====
// ----------------------------------------------------------------------------
// bdg_blend
// Density interpolation and threshold compare: a multiply stage, then the
// truncating scale, offset and compare into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bdg_blend (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [bdg_pkg::MIX_W-1:0]      in_mix,
   input  bdg_pkg::side_type              in_side,
   input  bdg_pkg::cfg_type               cfg,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [bdg_pkg::SCREEN_W-1:0]   out_screen_x,
   output logic [bdg_pkg::SCREEN_W-1:0]   out_screen_y,
   output logic                           out_paint_red
);
   import bdg_pkg::*;

   localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'((1 << MIX_SHIFT) - 1);

   logic                        mul_valid_ff;
   logic signed [PROD_W-1:0]    prod_ff, prod_in;
   side_type                    mul_side_ff;
   logic                        mul_ready;

   logic                        res_valid_ff;
   logic [SCREEN_W-1:0]         screen_x_ff;
   logic [SCREEN_W-1:0]         screen_y_ff;
   logic                        paint_ff, paint_in;
   logic                        res_ready;

   logic signed [DIFF_W-1:0]    diff;
   logic signed [PROD_W-1:0]    adj;
   logic signed [QUO_W-1:0]     quo;
   logic signed [DENSITY_W-1:0] density;

   assign diff    = $signed({1'b0, cfg.dens_end}) - $signed({1'b0, cfg.dens_begin});
   assign prod_in = PROD_W'(diff) * PROD_W'($signed({1'b0, in_mix}));

   // divide by 64 rounding toward zero
   assign adj      = prod_ff[PROD_W-1] ? prod_ff + ROUND_BIAS : prod_ff;
   assign quo      = $signed(adj[PROD_W-1:MIX_SHIFT]);
   assign density  = DENSITY_W'(quo) + DENSITY_W'($signed({1'b0, cfg.dens_begin}));
   assign paint_in = DENSITY_W'($signed({1'b0, mul_side_ff.thresh})) < density;

   assign res_ready = !res_valid_ff || out_ready;
   assign mul_ready = !mul_valid_ff || res_ready;
   assign in_ready  = mul_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         if (mul_ready) begin
            mul_valid_ff <= in_valid;
         end
         if (res_ready) begin
            res_valid_ff <= mul_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mul_ready && in_valid) begin
         prod_ff     <= prod_in;
         mul_side_ff <= in_side;
      end
      if (res_ready && mul_valid_ff) begin
         screen_x_ff <= mul_side_ff.screen_x;
         screen_y_ff <= mul_side_ff.screen_y;
         paint_ff    <= paint_in;
      end
   end

   assign out_valid     = res_valid_ff;
   assign out_screen_x  = screen_x_ff;
   assign out_screen_y  = screen_y_ff;
   assign out_paint_red = paint_ff;

endmodule

`default_nettype wire

// ===== hdl/bayer_dither_diagonal_gradient.sv =====
// ----------------------------------------------------------------------------
// bayer_dither_diagonal_gradient
// Diagonal ordered-dither gradient: maps pixel offsets in a rectangle to
// screen coordinates and an 8x8 threshold paint decision.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake          payload
//  req_chan  in    valid / ready      col[8:0], row[8:0]
//  rsp_chan  out   valid / ready      screen_x[9:0], screen_y[9:0], paint_red
//  csr_*     in    csr_write_en       csr_index[2:0], csr_write_data[9:0]
//
//  one item per clock sustained while the result side is ready; the path is an
//  input register, six divider stages of three quotient bits each, a multiply
//  stage and the result register
//  every stage has its own valid bit and loads whenever it is empty or its
//  successor moves, so stalls hold items in place and bubbles close up
//  synchronous reset clears the valid bits and resets the configuration registers
//
`default_nettype none

module bayer_dither_diagonal_gradient #(
   parameter int MAX_SPAN = 512
) (
   input  logic                             clock,
   input  logic                             reset,
   bdg_req_if.sink                          req_chan,
   bdg_rsp_if.source                        rsp_chan,
   input  logic                             csr_write_en,
   input  logic [bdg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bdg_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import bdg_pkg::*;

   localparam int SPAN_LIMIT = (1 << SPAN_REG_W) - 1;
   localparam int SPAN_CAP   = (MAX_SPAN < SPAN_LIMIT) ? MAX_SPAN : SPAN_LIMIT;
   localparam int DEN_W      = $clog2(3 * SPAN_CAP + 1);

   cfg_type            cfg;
   logic [DEN_W-1:0]   divisor;

   logic               s0_valid_ff;
   logic [DIV_W-1:0]   s0_nq_ff, s0_nq_in;
   side_type           s0_side_ff, s0_side_in;
   logic               s0_ready;
   logic [SUM_W-1:0]   diag_sum;

   logic [DIV_STEPS:0] stage_valid;
   logic [DIV_STEPS:0] stage_ready;
   logic [DIV_W-1:0]   stage_nq   [DIV_STEPS+1];
   logic [DEN_W-1:0]   stage_rem  [DIV_STEPS+1];
   side_type           stage_side [DIV_STEPS+1];

   bdg_csr #(
      .SPAN_CAP (SPAN_CAP),
      .DEN_W    (DEN_W)
   ) u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cfg            (cfg),
      .divisor        (divisor)
   );

   // numerator (2*col + row) * 64
   assign diag_sum = SUM_W'({req_chan.col, 1'b0}) + SUM_W'(req_chan.row);
   assign s0_nq_in = DIV_W'({diag_sum, {MIX_SHIFT{1'b0}}});

   assign s0_side_in.screen_x = SCREEN_W'(cfg.origin_x) + SCREEN_W'(req_chan.col);
   assign s0_side_in.screen_y = SCREEN_W'(cfg.origin_y) + SCREEN_W'(req_chan.row);
   assign s0_side_in.thresh   = bayer_thresh(req_chan.row[2:0], req_chan.col[2:0]);

   assign s0_ready       = !s0_valid_ff || stage_ready[0];
   assign req_chan.ready = s0_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (s0_ready) begin
         s0_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_ready && req_chan.valid) begin
         s0_nq_ff   <= s0_nq_in;
         s0_side_ff <= s0_side_in;
      end
   end

   assign stage_valid[0] = s0_valid_ff;
   assign stage_nq[0]    = s0_nq_ff;
   assign stage_rem[0]   = '0;
   assign stage_side[0]  = s0_side_ff;

   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
      bdg_div_step #(
         .DEN_W (DEN_W)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[g]),
         .in_ready  (stage_ready[g]),
         .in_nq     (stage_nq[g]),
         .in_rem    (stage_rem[g]),
         .in_side   (stage_side[g]),
         .divisor   (divisor),
         .out_valid (stage_valid[g+1]),
         .out_ready (stage_ready[g+1]),
         .out_nq    (stage_nq[g+1]),
         .out_rem   (stage_rem[g+1]),
         .out_side  (stage_side[g+1])
      );
   end

   // final remainder is not needed past the divider
   bdg_blend u_blend (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (stage_valid[DIV_STEPS]),
      .in_ready      (stage_ready[DIV_STEPS]),
      .in_mix        (stage_nq[DIV_STEPS][MIX_W-1:0]),
      .in_side       (stage_side[DIV_STEPS]),
      .cfg           (cfg),
      .out_valid     (rsp_chan.valid),
      .out_ready     (rsp_chan.ready),
      .out_screen_x  (rsp_chan.screen_x),
      .out_screen_y  (rsp_chan.screen_y),
      .out_paint_red (rsp_chan.paint_red)
   );

`ifndef SYNTHESIS
   a_rsp_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result valid right after reset");
   a_accept_fills_input_stage: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> s0_valid_ff)
      else $error("accepted item missing from input stage");
   a_input_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s0_valid_ff && !stage_ready[0] |=> s0_valid_ff && $stable(s0_nq_ff))
      else $error("stalled item in input stage changed");
   a_mix_in_range: assert property (@(posedge clock) disable iff (reset)
      stage_valid[DIV_STEPS] |-> stage_nq[DIV_STEPS][DIV_W-1:MIX_W] == '0)
      else $error("blend position overflows its width");
   a_final_remainder_below_divisor: assert property (@(posedge clock) disable iff (reset)
      stage_valid[DIV_STEPS] |-> stage_rem[DIV_STEPS] < divisor)
      else $error("divider remainder not reduced");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/bdg_paint_checker.sv =====
// ----------------------------------------------------------------------------
// bdg_paint_checker
// Watches the configuration port and both channels of the dither gradient.
// It keeps its own copy of the registers, works out the screen coordinate and
// paint flag of every accepted pixel item, and compares each result item in
// order against the oldest expectation.
// ----------------------------------------------------------------------------
`default_nettype none

module bdg_paint_checker #(
   parameter int MAX_SPAN = 512
) (
   input  logic                             clock,
   input  logic                             reset,
   bdg_req_if                               req_mon,
   bdg_rsp_if                               rsp_mon,
   input  logic                             csr_write_en,
   input  logic [bdg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bdg_pkg::CSR_DATA_W-1:0]   csr_write_data,
   output int                               mismatch_count,
   output int                               outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   import bdg_pkg::*;

   localparam int REPORT_LIMIT = 10;
   localparam int FULL_SCALE   = 64;

   localparam int BAYER8 [8][8] = '{
      '{ 0, 48, 12, 60,  3, 51, 15, 63},
      '{32, 16, 44, 28, 35, 19, 47, 31},
      '{ 8, 56,  4, 52, 11, 59,  7, 55},
      '{40, 24, 36, 20, 43, 27, 39, 23},
      '{ 2, 50, 14, 62,  1, 49, 13, 61},
      '{34, 18, 46, 30, 33, 17, 45, 29},
      '{10, 58,  6, 54,  9, 57,  5, 53},
      '{42, 26, 38, 22, 41, 25, 37, 21}
   };

   typedef struct {
      logic [COL_W-1:0]    col;
      logic [COL_W-1:0]    row;
      logic [SCREEN_W-1:0] screen_x;
      logic [SCREEN_W-1:0] screen_y;
      logic                paint_red;
   } painted_pixel_type;

   logic [COL_W-1:0]      win_ox;
   logic [COL_W-1:0]      win_oy;
   logic [SPAN_REG_W-1:0] win_w;
   logic [SPAN_REG_W-1:0] win_h;
   logic [DENS_W-1:0]     dens_start;
   logic [DENS_W-1:0]     dens_stop;

   painted_pixel_type expected_pixels [$];

   function automatic int span_of(logic [SPAN_REG_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_SPAN) return MAX_SPAN;
      return int'(v);
   endfunction

   function automatic int level_of(logic [DENS_W-1:0] v);
      return (v > FULL_SCALE) ? FULL_SCALE : int'(v);
   endfunction

   function automatic painted_pixel_type shade_pixel(logic [COL_W-1:0] c,
                                                     logic [COL_W-1:0] r);
      painted_pixel_type px;
      int mix;
      int density;
      int lo;
      int hi;
      lo = level_of(dens_start);
      hi = level_of(dens_stop);
      mix = ((2 * int'(c) + int'(r)) * FULL_SCALE) / (2 * span_of(win_w) + span_of(win_h));
      // signed int division truncates toward zero, as the gradient needs
      density = lo + ((hi - lo) * mix) / FULL_SCALE;
      px.col = c;
      px.row = r;
      px.screen_x = SCREEN_W'({1'b0, win_ox} + {1'b0, c});
      px.screen_y = SCREEN_W'({1'b0, win_oy} + {1'b0, r});
      px.paint_red = (BAYER8[r[2:0]][c[2:0]] < density);
      return px;
   endfunction

   always @(posedge clock) begin
      painted_pixel_type want;
      if (reset) begin
         win_ox = '0;
         win_oy = '0;
         win_w = SPAN_REG_W'(1);
         win_h = SPAN_REG_W'(1);
         dens_start = '0;
         dens_stop = '0;
         expected_pixels.delete();
         mismatch_count <= 0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_ORIGIN_X:   win_ox = csr_write_data[COL_W-1:0];
               CSR_ORIGIN_Y:   win_oy = csr_write_data[COL_W-1:0];
               CSR_WIDTH:      win_w = csr_write_data[SPAN_REG_W-1:0];
               CSR_HEIGHT:     win_h = csr_write_data[SPAN_REG_W-1:0];
               CSR_DENS_BEGIN: dens_start = csr_write_data[DENS_W-1:0];
               CSR_DENS_END:   dens_stop = csr_write_data[DENS_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            expected_pixels.push_back(shade_pixel(req_mon.col, req_mon.row));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_pixels.size() == 0) begin
               if (mismatch_count < REPORT_LIMIT)
                  $display("%0t: unexpected result item x %0d y %0d red %0b", $realtime,
                           rsp_mon.screen_x, rsp_mon.screen_y, rsp_mon.paint_red);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_mon.screen_x !== want.screen_x || rsp_mon.screen_y !== want.screen_y ||
                   rsp_mon.paint_red !== want.paint_red) begin
                  if (mismatch_count < REPORT_LIMIT)
                     $display("%0t: col %0d row %0d expected x %0d y %0d red %0b, got x %0d y %0d red %0b",
                              $realtime, want.col, want.row, want.screen_x, want.screen_y,
                              want.paint_red, rsp_mon.screen_x, rsp_mon.screen_y,
                              rsp_mon.paint_red);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
      end
      outstanding <= expected_pixels.size();
   end

   initial begin
      mismatch_count = 0;
      outstanding = 0;
   end

endmodule

`default_nettype wire

// ===== tb/sv/bayer_dither_diagonal_gradient_tb.sv =====
// ----------------------------------------------------------------------------
// bayer_dither_diagonal_gradient_tb
// Drives pixel offset items through the dither gradient under several
// rectangle and density settings: a directed pass over the corner cases, then
// random phases with random idling on both channels and one long output stall.
// The checker beside the block decides correctness; this module gives the
// verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module bayer_dither_diagonal_gradient_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bdg_pkg::*;

   localparam int MAX_SPAN      = 512;
   localparam int MAX_WAIT      = 13;
   localparam int CHOKE_CYCLES  = 80;
   localparam int DRAIN_CYCLES  = 12;
   localparam int RANDOM_ITEMS  = 1028;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 3'd7;

   typedef struct {
      logic [CSR_DATA_W-1:0] origin_x;
      logic [CSR_DATA_W-1:0] origin_y;
      logic [CSR_DATA_W-1:0] width;
      logic [CSR_DATA_W-1:0] height;
      logic [CSR_DATA_W-1:0] dens_start;
      logic [CSR_DATA_W-1:0] dens_stop;
   } region_setting_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;
   int                    mismatch_count;
   int                    outstanding;

   bit send_idle_on;
   bit rsp_stall_on;
   bit choke_request;
   int eff_w;
   int eff_h;

   bdg_req_if req_chan ();
   bdg_rsp_if rsp_chan ();

   bayer_dither_diagonal_gradient #(
      .MAX_SPAN(MAX_SPAN)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   bdg_paint_checker #(
      .MAX_SPAN(MAX_SPAN)
   ) checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // result side: one stall draw per accepted item, or the long hold-off
   initial begin
      int hold;
      hold = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_chan.ready <= 1'b0;
            hold--;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            if (choke_request) begin
               hold = CHOKE_CYCLES;
               choke_request = 1'b0;
            end else begin
               hold = rsp_stall_on ? int'($urandom_range(0, MAX_WAIT)) : 0;
            end
         end
      end
   end

   function automatic int span_of(logic [CSR_DATA_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_SPAN) return MAX_SPAN;
      return int'(v);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_span();
      case ($urandom_range(0, 4))
         0:       return CSR_DATA_W'($urandom_range(0, 1023));
         1:       return CSR_DATA_W'($urandom_range(65, MAX_SPAN));
         default: return CSR_DATA_W'($urandom_range(1, 64));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_level();
      case ($urandom_range(0, 5))
         0:       return CSR_DATA_W'($urandom_range(0, 1023));
         1:       return $urandom_range(0, 1) ? CSR_DATA_W'(64) : CSR_DATA_W'(0);
         default: return CSR_DATA_W'($urandom_range(0, 64));
      endcase
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(negedge clock);
   endtask

   task automatic load_setting(input region_setting_type s, input bit with_spare);
      write_reg(CSR_ORIGIN_X, s.origin_x);
      write_reg(CSR_ORIGIN_Y, s.origin_y);
      write_reg(CSR_WIDTH, s.width);
      write_reg(CSR_HEIGHT, s.height);
      write_reg(CSR_DENS_BEGIN, s.dens_start);
      write_reg(CSR_DENS_END, s.dens_stop);
      // unknown indexes must leave every register alone
      if (with_spare) begin
         write_reg(CSR_SPARE_A, CSR_DATA_W'($urandom_range(0, 1023)));
         write_reg(CSR_SPARE_B, 10'h3FF);
      end
      csr_write_en <= 1'b0;
      eff_w = span_of(s.width);
      eff_h = span_of(s.height);
   endtask

   task automatic send_pixel(input logic [COL_W-1:0] c, input logic [COL_W-1:0] r);
      int gap;
      gap = send_idle_on ? int'($urandom_range(0, MAX_WAIT)) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.col <= c;
      req_chan.row <= r;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      @(negedge clock);
   endtask

   // block is idle once every accepted item has produced its result
   task automatic drain_pixels();
      req_chan.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic pick_idling();
      int mode;
      mode = $urandom_range(0, 3);
      send_idle_on = mode[0];
      rsp_stall_on = mode[1];
   endtask

   initial begin
      region_setting_type s;
      int random_sent;
      int phase_len;
      int phase_no;
      logic [COL_W-1:0] c;
      logic [COL_W-1:0] r;

      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = CSR_ORIGIN_X;
      csr_write_data = '0;
      req_chan.valid = 1'b0;
      req_chan.col = '0;
      req_chan.row = '0;
      send_idle_on = 1'b0;
      rsp_stall_on = 1'b0;
      choke_request = 1'b0;
      eff_w = 1;
      eff_h = 1;

      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset values: zero density, unit rectangle at the screen origin
      send_pixel(9'd0, 9'd0);
      send_pixel(9'd5, 9'd9);
      drain_pixels();

      // full rectangle, full ramp from empty to solid
      pick_idling();
      s = '{origin_x: 0, origin_y: 0, width: 512, height: 512, dens_start: 0, dens_stop: 64};
      load_setting(s, 1'b0);
      send_pixel(9'd0, 9'd0);
      send_pixel(9'd511, 9'd0);
      send_pixel(9'd0, 9'd511);
      send_pixel(9'd511, 9'd511);
      send_pixel(9'd256, 9'd255);
      send_pixel(9'd3, 9'd5);
      send_pixel(9'd7, 9'd7);
      drain_pixels();

      // zero width, oversize height, densities past full scale, top origin
      pick_idling();
      s = '{origin_x: 10'h3FF, origin_y: 511, width: 0, height: 1023,
            dens_start: 100, dens_stop: 127};
      load_setting(s, 1'b1);
      send_pixel(9'd0, 9'd0);
      send_pixel(9'd511, 9'd511);
      send_pixel(9'd300, 9'd400);
      send_pixel(9'd1, 9'd1);
      drain_pixels();

      // falling ramp, offsets inside, just past and far outside a small rectangle
      pick_idling();
      s = '{origin_x: 0, origin_y: 0, width: 8, height: 8, dens_start: 64, dens_stop: 0};
      load_setting(s, 1'b0);
      send_pixel(9'd0, 9'd0);
      send_pixel(9'd7, 9'd7);
      send_pixel(9'd511, 9'd511);
      send_pixel(9'd8, 9'd0);
      send_pixel(9'd0, 9'd8);
      drain_pixels();

      // shallow falling ramp where the negative step truncates toward zero
      pick_idling();
      s = '{origin_x: 256, origin_y: 1, width: 1023, height: 0, dens_start: 5, dens_stop: 0};
      load_setting(s, 1'b0);
      send_pixel(9'd100, 9'd3);
      send_pixel(9'd511, 9'd100);
      send_pixel(9'd13, 9'd0);
      send_pixel(9'd200, 9'd200);
      drain_pixels();

      random_sent = 0;
      phase_no = 0;
      while (random_sent < RANDOM_ITEMS) begin
         s.origin_x = CSR_DATA_W'($urandom_range(0, 1023));
         s.origin_y = CSR_DATA_W'($urandom_range(0, 1023));
         s.width = pick_span();
         s.height = pick_span();
         s.dens_start = pick_level();
         s.dens_stop = pick_level();
         load_setting(s, $urandom_range(0, 3) == 0);
         pick_idling();
         if (phase_no == 2) begin
            // sender keeps offering while the result side holds off
            send_idle_on = 1'b0;
            choke_request = 1'b1;
         end
         phase_len = $urandom_range(40, 110);
         if (phase_len > RANDOM_ITEMS - random_sent) begin
            phase_len = RANDOM_ITEMS - random_sent;
         end
         repeat (phase_len) begin
            if ($urandom_range(0, 4) == 0) begin
               c = COL_W'($urandom_range(0, 511));
               r = COL_W'($urandom_range(0, 511));
            end else begin
               c = COL_W'($urandom_range(0, eff_w - 1));
               r = COL_W'($urandom_range(0, eff_h - 1));
            end
            send_pixel(c, r);
            random_sent++;
         end
         drain_pixels();
         phase_no++;
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire
